[rtl/csem_pkg.sv]
package csem_pkg;

	localparam int COUNT_W = 16;
	localparam int INIT_W  = 15;
	localparam int TID_W   = 8;
	localparam int STAT_W  = 2;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

	localparam logic OP_DOWN = 1'b0;
	localparam logic OP_UP   = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_SAT  = 2'd2;

	typedef struct packed {
		logic accept;
		logic load_wake;
	} cmd_t;

	typedef struct packed {
		logic wake;
	} sts_t;

	typedef struct packed {
		logic              blocked;
		logic              woken_valid;
		logic [TID_W-1:0]  woken_thread;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

[rtl/csem_if.sv]
interface csem_req_if;
	logic                            valid;
	logic                            ready;
	logic                            operation;
	logic [csem_pkg::TID_W-1:0]      thread_id;

	modport source (output valid, output operation, output thread_id, input ready);
	modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

interface csem_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            blocked;
	logic                            woken_valid;
	logic [csem_pkg::TID_W-1:0]      woken_thread;
	logic [csem_pkg::STAT_W-1:0]     status;

	modport source (output valid, output blocked, output woken_valid, output woken_thread,
		output status, input ready);
	modport sink   (input valid, input blocked, input woken_valid, input woken_thread,
		input status, output ready);
endinterface

[rtl/csem_ram.sv]
module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/csem_datapath.sv]
module csem_datapath #(
	parameter int WAITER_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [csem_pkg::INIT_W-1:0]       cfg_data,
	input  logic                              operation,
	input  logic [csem_pkg::TID_W-1:0]        thread_id,
	input  csem_pkg::cmd_t                    cmd,
	output csem_pkg::sts_t                    sts,
	output csem_pkg::result_t                 res
);

	localparam int PTR_W  = WAITER_DEPTH > 1 ? $clog2(WAITER_DEPTH) : 1;
	localparam int FILL_W = $clog2(WAITER_DEPTH + 1);

	logic signed [csem_pkg::COUNT_W-1:0] count_q, count_nx;
	logic [PTR_W-1:0]                    head_q, head_nx, tail_q, tail_nx;
	logic [FILL_W-1:0]                   fill_q, fill_nx;
	logic                                ram_we, ram_re;
	logic [csem_pkg::TID_W-1:0]          ram_rdata;
	logic                                blocked_nx, wvalid_nx;
	logic [csem_pkg::STAT_W-1:0]         status_nx;
	logic                                blocked_q, wvalid_q;
	logic [csem_pkg::TID_W-1:0]          wthread_q;
	logic [csem_pkg::STAT_W-1:0]         status_q;
	logic                                fifo_full, fifo_empty, count_le0;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(WAITER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign fifo_full  = (fill_q == FILL_W'(WAITER_DEPTH));
	assign fifo_empty = (fill_q == '0);
	assign count_le0  = count_q[csem_pkg::COUNT_W-1] || (count_q == '0);
	assign sts.wake   = (operation == csem_pkg::OP_UP) && !fifo_empty;

	always_comb begin
		count_nx   = count_q;
		head_nx    = head_q;
		tail_nx    = tail_q;
		fill_nx    = fill_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		blocked_nx = 1'b0;
		wvalid_nx  = 1'b0;
		status_nx  = csem_pkg::STATUS_OK;
		if (operation == csem_pkg::OP_DOWN) begin
			if (count_le0) begin
				if (fifo_full) begin
					status_nx = csem_pkg::STATUS_FULL;
				end else begin
					ram_we     = cmd.accept;
					tail_nx    = next_slot(tail_q);
					fill_nx    = fill_q + FILL_W'(1);
					blocked_nx = 1'b1;
					if (count_q == csem_pkg::COUNT_MIN) begin
						status_nx = csem_pkg::STATUS_SAT;
					end else begin
						count_nx = count_q - 16'sd1;
					end
				end
			end else begin
				count_nx = count_q - 16'sd1;
			end
		end else begin
			if (count_q == csem_pkg::COUNT_MAX) begin
				status_nx = csem_pkg::STATUS_SAT;
			end else begin
				count_nx = count_q + 16'sd1;
			end
			if (!fifo_empty) begin
				ram_re    = cmd.accept;
				head_nx   = next_slot(head_q);
				fill_nx   = fill_q - FILL_W'(1);
				wvalid_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
		end else if (cfg_we) begin
			count_q <= {1'b0, cfg_data};
		end else if (cmd.accept) begin
			count_q <= count_nx;
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			fill_q  <= fill_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			blocked_q <= blocked_nx;
			wvalid_q  <= wvalid_nx;
			status_q  <= status_nx;
			wthread_q <= '0;
		end
		if (cmd.load_wake) begin
			wthread_q <= ram_rdata;
		end
	end

	csem_ram #(
		.WIDTH(csem_pkg::TID_W),
		.DEPTH(WAITER_DEPTH)
	) u_waiters (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(thread_id),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign res.blocked      = blocked_q;
	assign res.woken_valid  = wvalid_q;
	assign res.woken_thread = wthread_q;
	assign res.status       = status_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WAITER_DEPTH))
		else $error("wait queue fill above depth");
`endif

endmodule

[rtl/csem_ctrl.sv]
module csem_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  csem_pkg::sts_t sts,
	output csem_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WAKE = 1'b1;

	logic state_q, state_nx;
	logic rsp_valid_q;

	assign req_ready     = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign cmd.accept    = req_valid && req_ready;
	assign cmd.load_wake = (state_q == ST_WAKE);
	assign rsp_valid     = rsp_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && sts.wake) begin
					state_nx = ST_WAKE;
				end
			end
			ST_WAKE: begin
				state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if ((cmd.accept && !sts.wake) || cmd.load_wake) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_wake_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAKE |-> !rsp_valid_q)
		else $error("wake word would overwrite pending result");
	a_wake_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAKE |=> state_q == ST_IDLE && rsp_valid_q)
		else $error("wake result not presented");
	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !sts.wake |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("single-cycle word gave no result");
`endif

endmodule

[rtl/counting_semaphore_wait_queue.sv]
// Channel | Dir | Fields                                          | Accept
// req     | in  | operation[0], thread_id[7:0]                    | valid & ready
// rsp     | out | blocked, woken_valid, woken_thread[7:0], status | valid & ready
// cfg     | in  | cfg_data[14:0] (initial_count)                  | cfg_we
// A down word, or an up word on an empty queue, gives its result in the next cycle.
// Waking a waiter adds a state that takes no word: the queue RAM read is registered.
// Reset (arst_n low) clears count, queue pointers and fill; queue RAM is not cleared.
// A result sits in one output register; a new word is taken when it drains or is empty.
module counting_semaphore_wait_queue #(
	parameter int WAITER_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [csem_pkg::INIT_W-1:0] cfg_data,
	csem_req_if.sink                    req,
	csem_rsp_if.source                  rsp
);

	csem_pkg::cmd_t    cmd;
	csem_pkg::sts_t    sts;
	csem_pkg::result_t res;

	csem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csem_datapath #(
		.WAITER_DEPTH(WAITER_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.operation(req.operation),
		.thread_id(req.thread_id),
		.cmd      (cmd),
		.sts      (sts),
		.res      (res)
	);

	assign rsp.blocked      = res.blocked;
	assign rsp.woken_valid  = res.woken_valid;
	assign rsp.woken_thread = res.woken_thread;
	assign rsp.status       = res.status;

endmodule
